>>> hw/rtl/ace_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants of the ANSI cell stream encoder.
// ----------------------------------------------------------------------------
package ace_pkg;

  // field widths
  localparam int unsigned CodeW = 7;
  localparam int unsigned ByteW = 8;

  // fixed bytes of the terminal stream
  localparam logic [ByteW-1:0] EscByte    = 8'h1B;
  localparam logic [ByteW-1:0] LbrByte    = 8'h5B;  // '['
  localparam logic [ByteW-1:0] HomeByte   = 8'h48;  // 'H'
  localparam logic [ByteW-1:0] SgrEndByte = 8'h6D;  // 'm'
  localparam logic [ByteW-1:0] SepByte    = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] BgPrefByte = 8'h34;  // '4'
  localparam logic [ByteW-1:0] ZeroByte   = 8'h30;  // '0'
  localparam logic [ByteW-1:0] UtfLead    = 8'hE2;
  localparam logic [ByteW-1:0] UtfSecond  = 8'h96;
  localparam logic [ByteW-1:0] GlyphLight = 8'h91;
  localparam logic [ByteW-1:0] GlyphMed   = 8'h92;
  localparam logic [ByteW-1:0] GlyphDark  = 8'h93;
  localparam logic [ByteW-1:0] GlyphFull  = 8'h88;

  // byte slots of one cell, in stream order
  localparam int unsigned NumSlots = 17;
  localparam int unsigned SlotW    = 5;
  localparam logic [SlotW-1:0] SLOT_HOME_ESC = 5'd0;
  localparam logic [SlotW-1:0] SLOT_HOME_LBR = 5'd1;
  localparam logic [SlotW-1:0] SLOT_HOME_H   = 5'd2;
  localparam logic [SlotW-1:0] SLOT_RST_ESC  = 5'd3;
  localparam logic [SlotW-1:0] SLOT_RST_LBR  = 5'd4;
  localparam logic [SlotW-1:0] SLOT_RST_M    = 5'd5;
  localparam logic [SlotW-1:0] SLOT_SGR_ESC  = 5'd6;
  localparam logic [SlotW-1:0] SLOT_SGR_LBR  = 5'd7;
  localparam logic [SlotW-1:0] SLOT_FG_HI    = 5'd8;
  localparam logic [SlotW-1:0] SLOT_FG_LO    = 5'd9;
  localparam logic [SlotW-1:0] SLOT_SEP      = 5'd10;
  localparam logic [SlotW-1:0] SLOT_BG_PREF  = 5'd11;
  localparam logic [SlotW-1:0] SLOT_BG_LO    = 5'd12;
  localparam logic [SlotW-1:0] SLOT_SGR_M    = 5'd13;
  localparam logic [SlotW-1:0] SLOT_UTF_LEAD = 5'd14;
  localparam logic [SlotW-1:0] SLOT_UTF_2ND  = 5'd15;
  localparam logic [SlotW-1:0] SLOT_CHAR     = 5'd16;

  // everything the byte sequencer needs for one cell
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [ByteW-1:0]    fg_hi;
    logic [ByteW-1:0]    fg_lo;
    logic [ByteW-1:0]    bg_lo;
    logic [ByteW-1:0]    char_byte;
  } cell_plan_t;

endpackage

>>> hw/rtl/ace_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_cell_if / ace_byte_if
// Valid/ready channels for screen cells in and stream bytes out.
// ----------------------------------------------------------------------------
interface ace_cell_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic       row_start;
  logic [6:0] fg_code;
  logic [6:0] bg_code;
  logic [7:0] char_code;

  modport source (output valid, frame_start, row_start, fg_code, bg_code, char_code,
                  input ready);
  modport sink (input valid, frame_start, row_start, fg_code, bg_code, char_code,
                output ready);
endinterface

interface ace_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

>>> hw/rtl/ace_byte_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_byte_seq
// Walks the enabled byte slots of one cell plan, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ace_byte_seq import ace_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         plan_valid_i,
  input  cell_plan_t   plan_i,
  output logic         plan_ready_o,
  ace_byte_if.source   byte_o
);

  logic [NumSlots-1:0] mask_q, mask_d;
  logic [ByteW-1:0]    fg_hi_q, fg_lo_q, bg_lo_q, char_q;
  logic                out_valid_q;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic                out_last_q;

  logic [NumSlots-1:0] first_bit;
  logic [NumSlots-1:0] rest;
  logic [SlotW-1:0]    slot;
  logic                out_load;
  logic                plan_load;

  // lowest pending slot goes next
  assign first_bit = mask_q & (~mask_q + NumSlots'(1));
  assign rest      = mask_q & ~first_bit;

  always_comb begin
    slot = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (first_bit[i]) slot = SlotW'(i);
    end
  end

  // byte for the selected slot
  always_comb begin
    unique case (slot)
      SLOT_HOME_ESC, SLOT_RST_ESC, SLOT_SGR_ESC: out_byte_d = EscByte;
      SLOT_HOME_LBR, SLOT_RST_LBR, SLOT_SGR_LBR: out_byte_d = LbrByte;
      SLOT_HOME_H:                               out_byte_d = HomeByte;
      SLOT_RST_M, SLOT_SGR_M:                    out_byte_d = SgrEndByte;
      SLOT_FG_HI:                                out_byte_d = fg_hi_q;
      SLOT_FG_LO:                                out_byte_d = fg_lo_q;
      SLOT_SEP:                                  out_byte_d = SepByte;
      SLOT_BG_PREF:                              out_byte_d = BgPrefByte;
      SLOT_BG_LO:                                out_byte_d = bg_lo_q;
      SLOT_UTF_LEAD:                             out_byte_d = UtfLead;
      SLOT_UTF_2ND:                              out_byte_d = UtfSecond;
      SLOT_CHAR:                                 out_byte_d = char_q;
      default:                                   out_byte_d = char_q;
    endcase
  end

  // output stage takes a byte when empty or being drained
  assign out_load     = (|mask_q) && (!out_valid_q || byte_o.ready);
  assign plan_ready_o = (mask_q == '0) || (out_load && (rest == '0));
  assign plan_load    = plan_valid_i && plan_ready_o;

  always_comb begin
    mask_d = mask_q;
    if (out_load) mask_d = rest;
    if (plan_load) mask_d = plan_i.mask;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (plan_load) begin
      fg_hi_q <= plan_i.fg_hi;
      fg_lo_q <= plan_i.fg_lo;
      bg_lo_q <= plan_i.bg_lo;
      char_q  <= plan_i.char_byte;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= (slot == SLOT_CHAR);
    end
  end

  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.last     = out_last_q;

endmodule

>>> hw/rtl/ansi_cell_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_cell_stream_encoder
// Turns screen cells into an ANSI terminal byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   cell_i takes one screen cell per item (frame/row start flags, fg and bg
//   SGR codes, character byte). byte_o gives the terminal stream one byte per
//   item; last marks the final glyph byte of each cell.
//   A cell produces 1 to 17 bytes: cursor home on frame start, attribute
//   reset on row start, an SGR color sequence when a color changes, then the
//   glyph (shade and block codes expand to three UTF-8 bytes).
//   The cell's byte plan is registered in the sequencer when the cell is
//   accepted; each byte then passes through the output register to byte_o.
//   The sequencer moves one byte per cycle into the output register while
//   byte_o is not stalled; the next cell is accepted in the cycle its
//   predecessor's last byte moves into the output register, so bytes stream
//   without gaps.
//   When byte_o stalls, the output register holds its byte and cell_i drops
//   ready once the current cell's bytes are pending.
//   Reset empties the sequencer and output register and marks both current
//   colors unknown, so the first cell always sends a color sequence.
// ----------------------------------------------------------------------------
module ansi_cell_stream_encoder import ace_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ace_cell_if.sink   cell_i,
  ace_byte_if.source byte_o
);

  logic [CodeW-1:0] cur_fg_q, cur_bg_q;
  logic             fg_known_q, bg_known_q;

  logic             cell_accept;
  logic             plan_ready;
  logic             fg_diff, bg_diff, any_diff, is_glyph;
  logic [14:0]      fg_prod, bg_prod;
  logic [3:0]       fg_tens, bg_tens;
  logic [CodeW-1:0] fg_ones, bg_ones;
  cell_plan_t       plan;

  assign cell_accept  = cell_i.valid && plan_ready;
  assign cell_i.ready = plan_ready;

  // color compare; a row start forgets both colors
  assign fg_diff  = cell_i.row_start || !fg_known_q || (cur_fg_q != cell_i.fg_code);
  assign bg_diff  = cell_i.row_start || !bg_known_q || (cur_bg_q != cell_i.bg_code);
  assign any_diff = fg_diff || bg_diff;

  // divide by ten via reciprocal, exact for 7-bit codes
  assign fg_prod = 15'(cell_i.fg_code) * 15'd205;
  assign bg_prod = 15'(cell_i.bg_code) * 15'd205;
  assign fg_tens = fg_prod[14:11];
  assign bg_tens = bg_prod[14:11];
  assign fg_ones = cell_i.fg_code - (CodeW'(fg_tens) * CodeW'(10));
  assign bg_ones = cell_i.bg_code - (CodeW'(bg_tens) * CodeW'(10));

  // shade and block glyphs
  always_comb begin
    case (cell_i.char_code)
      GlyphLight, GlyphMed, GlyphDark, GlyphFull: is_glyph = 1'b1;
      default:                                     is_glyph = 1'b0;
    endcase
  end

  // byte plan for this cell
  always_comb begin
    plan                      = '0;
    plan.mask[SLOT_HOME_ESC]  = cell_i.frame_start;
    plan.mask[SLOT_HOME_LBR]  = cell_i.frame_start;
    plan.mask[SLOT_HOME_H]    = cell_i.frame_start;
    plan.mask[SLOT_RST_ESC]   = cell_i.row_start;
    plan.mask[SLOT_RST_LBR]   = cell_i.row_start;
    plan.mask[SLOT_RST_M]     = cell_i.row_start;
    plan.mask[SLOT_SGR_ESC]   = any_diff;
    plan.mask[SLOT_SGR_LBR]   = any_diff;
    plan.mask[SLOT_FG_HI]     = fg_diff;
    plan.mask[SLOT_FG_LO]     = fg_diff;
    plan.mask[SLOT_SEP]       = fg_diff && bg_diff;
    plan.mask[SLOT_BG_PREF]   = bg_diff;
    plan.mask[SLOT_BG_LO]     = bg_diff;
    plan.mask[SLOT_SGR_M]     = any_diff;
    plan.mask[SLOT_UTF_LEAD]  = is_glyph;
    plan.mask[SLOT_UTF_2ND]   = is_glyph;
    plan.mask[SLOT_CHAR]      = 1'b1;
    plan.fg_hi                = ZeroByte + ByteW'(fg_tens);
    plan.fg_lo                = ZeroByte + ByteW'(fg_ones);
    plan.bg_lo                = ZeroByte + ByteW'(bg_ones);
    plan.char_byte            = cell_i.char_code;
  end

  // current colors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_fg_q   <= '0;
      cur_bg_q   <= '0;
      fg_known_q <= 1'b0;
      bg_known_q <= 1'b0;
    end else if (cell_accept) begin
      if (fg_diff) begin
        cur_fg_q   <= cell_i.fg_code;
        fg_known_q <= 1'b1;
      end
      if (bg_diff) begin
        cur_bg_q   <= cell_i.bg_code;
        bg_known_q <= 1'b1;
      end
    end
  end

  // byte sequencer and output register
  ace_byte_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (cell_i.valid),
    .plan_i       (plan),
    .plan_ready_o (plan_ready),
    .byte_o       (byte_o)
  );

  // after any cell both colors are known and match that cell
  a_colors_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_accept |=> fg_known_q && bg_known_q && (cur_fg_q == $past(cell_i.fg_code))
                    && (cur_bg_q == $past(cell_i.bg_code)))
    else $error("current colors not updated after cell");

  // a cell's bytes come without gaps once draining
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && byte_o.ready && !byte_o.last |=> byte_o.valid)
    else $error("gap inside a cell's byte sequence");

  // no new cell while a non-final byte is stuck in the output register
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid && !byte_o.ready && !byte_o.last |-> !cell_i.ready)
    else $error("cell accepted while previous cell unfinished");

endmodule

>>> verif/ansi_cell_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_cell_stream_encoder_tb
// Drives screen cells into the encoder and checks every stream byte and its
// last marker against a cycle-free predictor of the terminal byte sequence.
// Directed cells cover cursor home, attribute reset, each color change form,
// block glyphs and out-of-range codes; random frames follow under varying
// sender and receiver idling, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module ansi_cell_stream_encoder_tb import ace_pkg::*; ();

  localparam int unsigned StallCycles = 400;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic             frame;
    logic             row;
    logic [CodeW-1:0] fg;
    logic [CodeW-1:0] bg;
    logic [ByteW-1:0] ch;
  } cell_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_last;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ace_cell_if cell_if ();
  ace_byte_if byte_if ();

  ansi_cell_stream_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_if),
    .byte_o (byte_if)
  );

  // predictor state: colors last sent to the terminal
  logic [CodeW-1:0] term_fg;
  logic [CodeW-1:0] term_bg;
  logic             term_fg_known;
  logic             term_bg_known;

  stream_byte_t pending_bytes[$];
  int unsigned  mismatches = 0;
  int unsigned  cells_sent = 0;

  // idling rates in percent, and the long receiver hold-off request
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        stall_toggle = 1'b0;
  logic        stall_seen   = 1'b0;
  int unsigned stall_left   = 0;

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [ByteW-1:0] b);
    stream_byte_t sb;
    sb.data    = b;
    sb.is_last = 1'b0;
    pending_bytes.push_back(sb);
  endfunction

  function automatic void clear_terminal_colors();
    term_fg       = '0;
    term_bg       = '0;
    term_fg_known = 1'b0;
    term_bg_known = 1'b0;
  endfunction

  function automatic void encode_cell(input cell_t c);
    logic         fg_diff;
    logic         bg_diff;
    stream_byte_t tail;
    if (c.frame) begin
      push_byte(EscByte);
      push_byte(LbrByte);
      push_byte(HomeByte);
    end
    if (c.row) begin
      push_byte(EscByte);
      push_byte(LbrByte);
      push_byte(SgrEndByte);
      term_fg_known = 1'b0;
      term_bg_known = 1'b0;
    end
    fg_diff = !term_fg_known || (term_fg != c.fg);
    bg_diff = !term_bg_known || (term_bg != c.bg);
    if (fg_diff || bg_diff) begin
      push_byte(EscByte);
      push_byte(LbrByte);
      // tens digit runs past '9' for codes above 99
      if (fg_diff) begin
        push_byte(ZeroByte + ByteW'(c.fg / 10));
        push_byte(ZeroByte + ByteW'(c.fg % 10));
        term_fg       = c.fg;
        term_fg_known = 1'b1;
      end
      if (fg_diff && bg_diff) push_byte(SepByte);
      if (bg_diff) begin
        push_byte(BgPrefByte);
        push_byte(ZeroByte + ByteW'(c.bg % 10));
        term_bg       = c.bg;
        term_bg_known = 1'b1;
      end
      push_byte(SgrEndByte);
    end
    // shade and block glyphs go out as three utf-8 bytes
    if (c.ch == GlyphLight || c.ch == GlyphMed || c.ch == GlyphDark ||
        c.ch == GlyphFull) begin
      push_byte(UtfLead);
      push_byte(UtfSecond);
    end
    push_byte(c.ch);
    tail = pending_bytes.pop_back();
    tail.is_last = 1'b1;
    pending_bytes.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random ready, plus the long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else if (stall_toggle != stall_seen) begin
      stall_seen    <= stall_toggle;
      stall_left    <= StallCycles;
      byte_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int exp_val, input int act_val);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, exp_val,
               act_val);
  endtask

  always @(posedge clk_i) begin
    stream_byte_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 0, byte_if.out_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.out_byte !== want.data)
          report_mismatch("out_byte", want.data, byte_if.out_byte);
        if (byte_if.last !== want.is_last)
          report_mismatch("last", want.is_last, byte_if.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------
  task automatic send_cell(input cell_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid       <= 1'b1;
    cell_if.frame_start <= c.frame;
    cell_if.row_start   <= c.row;
    cell_if.fg_code     <= c.fg;
    cell_if.bg_code     <= c.bg;
    cell_if.char_code   <= c.ch;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    encode_cell(c);
    cells_sent++;
  endtask

  function automatic cell_t make_cell(input logic frame, input logic row,
                                      input int fg, input int bg, input int ch);
    cell_t c;
    c.frame = frame;
    c.row   = row;
    c.fg    = CodeW'(fg);
    c.bg    = CodeW'(bg);
    c.ch    = ByteW'(ch);
    return c;
  endfunction

  // stop offering items and wait for every expected byte
  task automatic wait_drained();
    cell_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      case ($urandom_range(3))
        0:       return GlyphLight;
        1:       return GlyphMed;
        2:       return GlyphDark;
        default: return GlyphFull;
      endcase
    end else if (sel < 85) begin
      return ByteW'($urandom_range(8'h7E, 8'h20));
    end
    return ByteW'($urandom_range(255));
  endfunction

  function automatic int pick_fg();
    return ($urandom_range(1) != 0) ? 30 + $urandom_range(7) : 90 + $urandom_range(7);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, each color change form, glyphs, start flag combinations
  task automatic test_directed();
    // colors unknown after reset, no row start needed for a color sequence
    send_cell(make_cell(1'b1, 1'b0, 30, 40, "A"));
    send_cell(make_cell(1'b0, 1'b0, 30, 40, "B"));
    send_cell(make_cell(1'b0, 1'b0, 31, 40, "C"));
    send_cell(make_cell(1'b0, 1'b0, 31, 47, "D"));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, "E"));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, GlyphFull));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, GlyphLight));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, GlyphMed));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, GlyphDark));
    // neighbors of the glyph codes and byte extremes
    send_cell(make_cell(1'b0, 1'b0, 97, 42, 8'h00));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, 8'hFF));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, 8'h87));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, 8'h90));
    send_cell(make_cell(1'b0, 1'b0, 97, 42, 8'h94));
    // frame start alone keeps the colors
    send_cell(make_cell(1'b1, 1'b0, 97, 42, "F"));
    // row start forgets them even when unchanged
    send_cell(make_cell(1'b0, 1'b1, 97, 42, "G"));
    // code extremes, single digit and beyond 99
    send_cell(make_cell(1'b0, 1'b0, 0, 0, "H"));
    send_cell(make_cell(1'b0, 1'b0, 127, 127, "I"));
    send_cell(make_cell(1'b0, 1'b0, 9, 127, "J"));
    send_cell(make_cell(1'b0, 1'b0, 99, 99, "K"));
    send_cell(make_cell(1'b0, 1'b0, 110, 99, "L"));
    // longest cell: both starts, both colors, glyph
    send_cell(make_cell(1'b1, 1'b1, 37, 44, GlyphDark));
    send_cell(make_cell(1'b1, 1'b1, 37, 44, "M"));
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering cells
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_toggle <= ~stall_toggle;
    for (int i = 0; i < 20; i++)
      send_cell(make_cell(i == 0, (i % 5) == 0, pick_fg(), 40 + $urandom_range(7),
                          pick_char()));
    wait_drained();
  endtask

  // well-formed frames of rows with random content, some noise cells mixed in
  task automatic test_random_frames(input int unsigned n_cells);
    int unsigned done;
    int unsigned rows;
    int unsigned width;
    int          fg;
    int          bg;
    cell_t       c;
    done = 0;
    fg   = pick_fg();
    bg   = 40 + $urandom_range(7);
    while (done < n_cells) begin
      rows = $urandom_range(4, 1);
      for (int r = 0; r < rows && done < n_cells; r++) begin
        width = $urandom_range(8, 1);
        for (int x = 0; x < width && done < n_cells; x++) begin
          if ($urandom_range(99) < 40) fg = pick_fg();
          if ($urandom_range(99) < 30) bg = 40 + $urandom_range(7);
          c = make_cell(r == 0 && x == 0, x == 0, fg, bg, pick_char());
          if ($urandom_range(99) < 15)
            c = make_cell(1'($urandom_range(1)), 1'($urandom_range(1)),
                          $urandom_range(127), $urandom_range(127), $urandom_range(255));
          send_cell(c);
          done++;
        end
      end
    end
  endtask

  task automatic test_idle_phases();
    // slow receiver
    tx_idle_pct = 7;
    rx_idle_pct = 63;
    test_random_frames(75);
    wait_drained();
    // slow sender
    tx_idle_pct = 63;
    rx_idle_pct = 7;
    test_random_frames(75);
    // no idling at all
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_frames(70);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni              <= 1'b0;
    cell_if.valid       <= 1'b0;
    cell_if.frame_start <= 1'b0;
    cell_if.row_start   <= 1'b0;
    cell_if.fg_code     <= '0;
    cell_if.bg_code     <= '0;
    cell_if.char_code   <= '0;
    clear_terminal_colors();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_idle_phases();

    if (pending_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", pending_bytes.size());
    end
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ace_pkg.sv
hw/rtl/ace_if.sv
hw/rtl/ace_byte_seq.sv
hw/rtl/ansi_cell_stream_encoder.sv
verif/ansi_cell_stream_encoder_tb.sv
